[design/bmsp_pkg.sv]
`default_nettype none

package bmsp_pkg;

	typedef enum logic [1:0] {
		KIND_CHANNEL       = 2'd0,
		KIND_SYSEX_BYTE    = 2'd1,
		KIND_SYSEX_DONE    = 2'd2,
		KIND_SYSEX_ABANDON = 2'd3
	} kind_t;

	localparam logic [7:0] SYSEX_START    = 8'hF0;
	localparam logic [7:0] SYSEX_END      = 8'hF7;
	localparam logic [7:0] REALTIME_FIRST = 8'hF8;

	// upper nibbles of status bytes
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	localparam int SYSEX_CAPACITY_DEFAULT = 256;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  voice_status;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [7:0]  sysex_value;
		logic [8:0]  sysex_total;
		logic        last_of_run;
	} result_t;

endpackage

`default_nettype wire

[design/ble_midi_stream_parser.sv]
// An accepted item passes through the input register and then the result queue
// before its first result appears on the outputs; a second result of the same
// item is queued with the first and is ready as soon as the first is taken.
// Throughput: one item per cycle while the queue has room for two results;
// a SysEx restart writes two results into the four-entry result queue.
// Reset (arst_n low, asynchronous): parser state cleared, no running status,
// no SysEx in progress, input register and result queue empty.
`default_nettype none

module ble_midi_stream_parser #(
	parameter int SYSEX_CAPACITY = bmsp_pkg::SYSEX_CAPACITY_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items
	input  wire logic       packet_valid,
	output logic            packet_stall,
	input  wire logic [7:0] packet_byte,
	input  wire logic       packet_start,
	// result items
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      kind,
	output logic [7:0]      voice_status,
	output logic [6:0]      first_data,
	output logic [6:0]      second_data,
	output logic [7:0]      sysex_value,
	output logic [8:0]      sysex_total,
	output logic            last_of_run
);

	// count must hold the capacity itself
	localparam int CW  = $clog2(SYSEX_CAPACITY + 1);
	localparam int QD  = 4;
	localparam int QAW = $clog2(QD);

	// ---------------------------------------------------------------- input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       take_in;

	// ---------------------------------------------------------------- parser state
	logic          ts_q;        // next byte follows a timestamp
	logic          active_q;    // SysEx in progress
	logic [CW-1:0] count_q;     // SysEx bytes so far
	logic [7:0]    rs_q;        // running status, zero = none
	logic [6:0]    held_q;      // first data byte awaiting the second
	logic          dpos_q;      // held_q is valid

	logic          ts_nx;
	logic          active_nx;
	logic [CW-1:0] count_nx;
	logic [7:0]    rs_nx;
	logic [6:0]    held_nx;
	logic          dpos_nx;

	logic              midi;
	logic [CW-1:0]     count_inc;
	logic              below_cap;
	logic [CW+8:0]     count_wide;
	logic [CW+8:0]     inc_wide;
	bmsp_pkg::result_t r0;
	bmsp_pkg::result_t r1;
	bmsp_pkg::result_t abandon_res;
	logic [1:0]        n_res;

	// ---------------------------------------------------------------- result queue
	bmsp_pkg::result_t queue_q [QD];
	logic [QAW-1:0]    wr_q;
	logic [QAW-1:0]    rd_q;
	logic [QAW:0]      qcount_q;
	logic              room;
	logic              pop;
	logic [1:0]        push_n;
	bmsp_pkg::result_t head;

	// Room for the worst case of two results per item; checked against the
	// registered count only, so stall never waits on the output side.
	assign room         = qcount_q <= (QAW+1)'(QD - 2);
	assign advance      = valid_s1 & room;
	assign packet_stall = valid_s1 & ~room;
	assign take_in      = packet_valid & ~packet_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1  <= packet_byte;
			start_s1 <= packet_start;
		end
	end

	// ---------------------------------------------------------------- per-byte decode
	assign count_inc  = count_q + 1'b1;
	assign below_cap  = count_q < CW'(SYSEX_CAPACITY);
	assign count_wide = (CW+9)'(count_q);
	assign inc_wide   = (CW+9)'(count_inc);

	always_comb begin
		abandon_res             = '0;
		abandon_res.kind        = bmsp_pkg::KIND_SYSEX_ABANDON;
		abandon_res.sysex_total = count_wide[8:0];
	end

	always_comb begin
		r0        = '0;
		r1        = '0;
		n_res     = 2'd0;
		active_nx = active_q;
		count_nx  = count_q;
		rs_nx     = rs_q;
		held_nx   = held_q;
		dpos_nx   = dpos_q;

		// header byte is dropped; an unmarked high byte is timestampLow
		midi  = ~start_s1 & (ts_q | ~byte_s1[7]);
		ts_nx = ~start_s1 & ~ts_q & byte_s1[7];

		if (midi) begin
			if (byte_s1 == bmsp_pkg::SYSEX_START) begin
				// restart abandons the open SysEx first
				if (active_q) begin
					r0    = abandon_res;
					n_res = 2'd2;
				end else begin
					n_res = 2'd1;
				end
				active_nx = 1'b1;
				count_nx  = CW'(1);
				rs_nx     = '0;
				if (active_q) begin
					r1.kind        = bmsp_pkg::KIND_SYSEX_BYTE;
					r1.sysex_value = bmsp_pkg::SYSEX_START;
				end else begin
					r0.kind        = bmsp_pkg::KIND_SYSEX_BYTE;
					r0.sysex_value = bmsp_pkg::SYSEX_START;
				end
			end else if (byte_s1 == bmsp_pkg::SYSEX_END) begin
				// stray end byte is ignored
				if (active_q) begin
					n_res     = 2'd1;
					active_nx = 1'b0;
					count_nx  = '0;
					if (below_cap) begin
						r0.kind        = bmsp_pkg::KIND_SYSEX_DONE;
						r0.sysex_value = bmsp_pkg::SYSEX_END;
						r0.sysex_total = inc_wide[8:0];
					end else begin
						r0 = abandon_res;
					end
				end
			end else if (byte_s1[7]) begin
				// real-time bytes leave everything untouched
				if (byte_s1 < bmsp_pkg::REALTIME_FIRST) begin
					if (active_q) begin
						r0        = abandon_res;
						n_res     = 2'd1;
						active_nx = 1'b0;
						count_nx  = '0;
					end
					if (byte_s1[7:4] != bmsp_pkg::NIB_SYSTEM) begin
						rs_nx   = byte_s1;
						dpos_nx = 1'b0;
					end else begin
						rs_nx = '0;
					end
				end
			end else if (active_q) begin
				n_res = 2'd1;
				if (below_cap) begin
					count_nx       = count_inc;
					r0.kind        = bmsp_pkg::KIND_SYSEX_BYTE;
					r0.sysex_value = byte_s1;
				end else begin
					r0        = abandon_res;
					active_nx = 1'b0;
					count_nx  = '0;
				end
			end else if (rs_q != '0) begin
				if (!dpos_q) begin
					if (rs_q[7:4] == bmsp_pkg::NIB_PROGRAM
					    || rs_q[7:4] == bmsp_pkg::NIB_PRESSURE) begin
						n_res           = 2'd1;
						r0.kind         = bmsp_pkg::KIND_CHANNEL;
						r0.voice_status = rs_q;
						r0.first_data   = byte_s1[6:0];
					end else begin
						held_nx = byte_s1[6:0];
						dpos_nx = 1'b1;
					end
				end else begin
					n_res           = 2'd1;
					r0.kind         = bmsp_pkg::KIND_CHANNEL;
					r0.voice_status = rs_q;
					r0.first_data   = held_q;
					r0.second_data  = byte_s1[6:0];
					dpos_nx         = 1'b0;
				end
			end
		end

		// flag the final result of this item
		if (n_res == 2'd1) begin
			r0.last_of_run = 1'b1;
		end else if (n_res == 2'd2) begin
			r1.last_of_run = 1'b1;
		end
	end

	// advance parser state only when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q     <= 1'b0;
			active_q <= 1'b0;
			count_q  <= '0;
			rs_q     <= '0;
			held_q   <= '0;
			dpos_q   <= 1'b0;
		end else if (advance) begin
			ts_q     <= ts_nx;
			active_q <= active_nx;
			count_q  <= count_nx;
			rs_q     <= rs_nx;
			held_q   <= held_nx;
			dpos_q   <= dpos_nx;
		end
	end

	// ---------------------------------------------------------------- result queue
	assign push_n = advance ? n_res : 2'd0;
	assign pop    = result_valid & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			qcount_q <= '0;
		end else begin
			wr_q     <= wr_q + QAW'(push_n);
			rd_q     <= rd_q + QAW'(pop);
			qcount_q <= qcount_q + (QAW+1)'(push_n) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_q] <= r0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_q + 1'b1] <= r1;
		end
	end

	assign head         = queue_q[rd_q];
	assign result_valid = qcount_q != '0;
	assign kind         = head.kind;
	assign voice_status = head.voice_status;
	assign first_data   = head.first_data;
	assign second_data  = head.second_data;
	assign sysex_value  = head.sysex_value;
	assign sysex_total  = head.sysex_total;
	assign last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

[design/bmsp_checker.sv]
`default_nettype none

module bmsp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       packet_valid,
	input wire logic       packet_stall,
	input wire logic [7:0] packet_byte,
	input wire logic       packet_start,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] voice_status,
	input wire logic [6:0] first_data,
	input wire logic [6:0] second_data,
	input wire logic [7:0] sysex_value,
	input wire logic [8:0] sysex_total,
	input wire logic       last_of_run
);

	logic unused_in;
	assign unused_in = packet_valid ^ packet_stall ^ (^packet_byte) ^ packet_start
		^ (^first_data) ^ (^second_data) ^ (^sysex_total);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind)
		&& $stable(sysex_value) && $stable(last_of_run))
		else $error("stalled result changed");

	// only an abandon can be followed by another result of the same item
	a_nonlast_abandon: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> kind == bmsp_pkg::KIND_SYSEX_ABANDON)
		else $error("non-final result is not an abandon");

	// the partner of a non-final result is ready right away
	a_pair_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_run |=> result_valid)
		else $error("second result of a pair missing");

	a_channel_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == bmsp_pkg::KIND_CHANNEL |->
		voice_status[7] && voice_status[7:4] != bmsp_pkg::NIB_SYSTEM)
		else $error("channel result without voice status");

	a_done_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == bmsp_pkg::KIND_SYSEX_DONE |->
		sysex_value == bmsp_pkg::SYSEX_END)
		else $error("completion result without end byte");

endmodule

bind ble_midi_stream_parser bmsp_checker u_bmsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.packet_valid (packet_valid),
	.packet_stall (packet_stall),
	.packet_byte  (packet_byte),
	.packet_start (packet_start),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.voice_status (voice_status),
	.first_data   (first_data),
	.second_data  (second_data),
	.sysex_value  (sysex_value),
	.sysex_total  (sysex_total),
	.last_of_run  (last_of_run)
);

`default_nettype wire

[verif/ble_midi_stream_parser_tb.sv]
`default_nettype none

module ble_midi_stream_parser_tb;

	// SysEx capacity used by both the parser and the predictor below.
	localparam int SYSEX_LIMIT = bmsp_pkg::SYSEX_CAPACITY_DEFAULT;
	// Count of packet bytes to queue, spread over four idle/stall phases.
	localparam int ITEM_TARGET = 1900;
	// Give up after this many cycles in which neither channel moves an item.
	localparam int STALL_LIMIT = 4000;
	// Quiet cycles after the last result, as a margin.
	localparam int DRAIN_CYCLES = 12;
	// Print at most this many failure lines; count every failure regardless.
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [7:0] value;
		logic       start;
	} packet_item_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       packet_valid = 1'b0;
	logic       packet_stall;
	logic [7:0] packet_byte  = 8'h00;
	logic       packet_start = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] voice_status;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [7:0] sysex_value;
	logic [8:0] sysex_total;
	logic       last_of_run;

	ble_midi_stream_parser #(
		.SYSEX_CAPACITY(SYSEX_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.packet_valid(packet_valid),
		.packet_stall(packet_stall),
		.packet_byte (packet_byte),
		.packet_start(packet_start),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.voice_status(voice_status),
		.first_data  (first_data),
		.second_data (second_data),
		.sysex_value (sysex_value),
		.sysex_total (sysex_total),
		.last_of_run (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus and scoreboard state shared between the processes below.
	packet_item_t      pending_items[$];
	bmsp_pkg::result_t expected_results[$];
	logic              in_taken     = 1'b0;
	int unsigned       idle_pct     = 0;
	int unsigned       stall_pct    = 0;
	int                items_queued = 0;
	int                items_accepted = 0;
	int                idle_cycles  = 0;
	int                error_count  = 0;
	int                kind_seen [4];

	// Parser state mirrored by the predictor.
	logic       ts_pending;
	logic       sx_open;
	int         sx_len;
	logic [7:0] run_status;
	logic [6:0] held_first;
	logic       have_first;

	initial begin
		ts_pending = 1'b0;
		sx_open    = 1'b0;
		sx_len     = 0;
		run_status = 8'h00;
		held_first = 7'h00;
		have_first = 1'b0;
	end

	// Number of data bytes a channel status takes; zero for system bytes.
	function automatic int data_count(logic [7:0] status);
		if (!status[7])
			return 0;
		case (status[7:4])
			bmsp_pkg::NIB_PROGRAM, bmsp_pkg::NIB_PRESSURE: return 1;
			bmsp_pkg::NIB_SYSTEM:                          return 0;
			default:                                       return 2;
		endcase
	endfunction

	function automatic void add_result(bmsp_pkg::kind_t k, logic [7:0] vs, logic [6:0] d1,
			logic [6:0] d2, logic [7:0] sv, int total);
		bmsp_pkg::result_t r;
		r.kind         = k;
		r.voice_status = vs;
		r.first_data   = d1;
		r.second_data  = d2;
		r.sysex_value  = sv;
		r.sysex_total  = total[8:0];
		r.last_of_run  = 1'b0;
		expected_results.push_back(r);
	endfunction

	// Close the open SysEx with an abandon result carrying the bytes seen so far.
	function automatic void drop_sysex();
		add_result(bmsp_pkg::KIND_SYSEX_ABANDON, 8'h00, 7'h00, 7'h00, 8'h00, sx_len);
		sx_open = 1'b0;
		sx_len  = 0;
	endfunction

	// Handle one byte that reached the MIDI layer (header and timestamp stripped).
	function automatic void parse_midi(logic [7:0] value);
		if (value == bmsp_pkg::SYSEX_START) begin
			if (sx_open)
				drop_sysex();
			sx_open    = 1'b1;
			sx_len     = 1;
			run_status = 8'h00;
			add_result(bmsp_pkg::KIND_SYSEX_BYTE, 8'h00, 7'h00, 7'h00, value, 0);
		end else if (value == bmsp_pkg::SYSEX_END) begin
			// A stray end byte does nothing; a full buffer turns it into an abandon.
			if (sx_open) begin
				if (sx_len < SYSEX_LIMIT) begin
					sx_len++;
					add_result(bmsp_pkg::KIND_SYSEX_DONE, 8'h00, 7'h00, 7'h00,
						bmsp_pkg::SYSEX_END, sx_len);
					sx_open = 1'b0;
					sx_len  = 0;
				end else begin
					drop_sysex();
				end
			end
		end else if (value[7]) begin
			// Real-time bytes pass through untouched; any other status ends a SysEx.
			if (value < bmsp_pkg::REALTIME_FIRST) begin
				if (sx_open)
					drop_sysex();
				if (data_count(value) != 0) begin
					run_status = value;
					have_first = 1'b0;
				end else begin
					run_status = 8'h00;
				end
			end
		end else if (sx_open) begin
			if (sx_len < SYSEX_LIMIT) begin
				sx_len++;
				add_result(bmsp_pkg::KIND_SYSEX_BYTE, 8'h00, 7'h00, 7'h00, value, 0);
			end else begin
				drop_sysex();
			end
		end else if (run_status != 8'h00) begin
			if (!have_first) begin
				if (data_count(run_status) == 1) begin
					add_result(bmsp_pkg::KIND_CHANNEL, run_status, value[6:0], 7'h00,
						8'h00, 0);
				end else begin
					held_first = value[6:0];
					have_first = 1'b1;
				end
			end else begin
				add_result(bmsp_pkg::KIND_CHANNEL, run_status, held_first, value[6:0],
					8'h00, 0);
				have_first = 1'b0;
			end
		end
	endfunction

	// Strip BLE framing from one accepted item, then flag the last result it caused.
	function automatic void predict_step(logic [7:0] value, logic start);
		int                before_n;
		bmsp_pkg::result_t tail;
		before_n = expected_results.size();
		if (start) begin
			ts_pending = 1'b0;
		end else if (ts_pending) begin
			ts_pending = 1'b0;
			parse_midi(value);
		end else if (value[7]) begin
			ts_pending = 1'b1;
		end else begin
			parse_midi(value);
		end
		if (expected_results.size() > before_n) begin
			tail = expected_results.pop_back();
			tail.last_of_run = 1'b1;
			expected_results.push_back(tail);
		end
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	// Driver: inputs change on the falling edge. Hold a payload until it is taken,
	// then load the next pending item unless this cycle is picked to idle.
	always @(negedge clk) begin : driver
		packet_item_t item;
		result_stall <= ($urandom_range(99) < stall_pct);
		if (!packet_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item = pending_items.pop_front();
				packet_valid <= 1'b1;
				packet_byte  <= item.value;
				packet_start <= item.start;
			end else begin
				packet_valid <= 1'b0;
			end
		end
	end

	// Monitor: sample both channels on the rising edge. Check results before
	// predicting, since an item accepted now cannot produce a result this edge.
	always @(posedge clk) begin : monitor
		bmsp_pkg::result_t want;
		if (arst_n) begin
			in_taken <= packet_valid && !packet_stall;
			if ((packet_valid && !packet_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("result of kind %0d arrived with none expected", kind);
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("voice_status", want.voice_status, voice_status);
					check_field("first_data", want.first_data, first_data);
					check_field("second_data", want.second_data, second_data);
					check_field("sysex_value", want.sysex_value, sysex_value);
					check_field("sysex_total", want.sysex_total, sysex_total);
					check_field("last_of_run", want.last_of_run, last_of_run);
					kind_seen[want.kind]++;
				end
			end
			if (packet_valid && !packet_stall) begin
				predict_step(packet_byte, packet_start);
				items_accepted++;
			end
		end
	end

	// Watchdog: end the run when neither channel has moved for too long.
	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT)
			@(negedge clk);
		$error("no item moved for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic queue_byte(input logic [7:0] value, input logic start);
		packet_item_t item;
		item.value = value;
		item.start = start;
		pending_items.push_back(item);
		items_queued++;
	endtask

	task automatic send_timestamp();
		queue_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
	endtask

	task automatic send_header();
		queue_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// A status byte only reaches the parser right after a timestamp byte.
	task automatic send_status(input logic [7:0] status);
		send_timestamp();
		queue_byte(status, 1'b0);
	endtask

	// Data bytes pass as they are; now and then put a timestamp in front.
	task automatic send_data(input logic [6:0] value);
		if ($urandom_range(7) == 0)
			send_timestamp();
		queue_byte({1'b0, value}, 1'b0);
	endtask

	task automatic long_sysex(input int len);
		send_status(bmsp_pkg::SYSEX_START);
		repeat (len)
			send_data(7'($urandom_range(0, 127)));
		send_status(bmsp_pkg::SYSEX_END);
	endtask

	task automatic directed_traffic();
		send_header();
		send_data(7'h00);                   // data with no status: dropped
		send_status(8'h90);
		send_data(7'h00);
		send_data(7'h7F);
		send_data(7'h7F);                   // running status
		send_status(8'hF8);                 // real-time between data bytes
		send_data(7'h00);
		send_status(8'hC5);                 // one data byte
		send_data(7'h7F);
		send_status(8'hF1);                 // system common clears status
		send_data(7'h11);
		send_status(bmsp_pkg::SYSEX_END);   // stray end
		send_status(bmsp_pkg::SYSEX_START);
		send_data(7'h01);
		send_status(8'hFE);                 // real-time inside SysEx
		queue_byte(8'hFF, 1'b1);            // header inside SysEx keeps it open
		send_data(7'h7F);
		send_status(bmsp_pkg::SYSEX_END);
		send_status(bmsp_pkg::SYSEX_START);
		send_data(7'h40);
		send_status(bmsp_pkg::SYSEX_START); // restart: abandon plus new start
		send_data(7'h22);
		send_status(8'hEF);                 // interrupt by a channel status
		send_data(7'h00);
		send_data(7'h7F);
		send_status(bmsp_pkg::SYSEX_START);
		send_status(8'hF4);                 // interrupt by system common
	endtask

	task automatic random_traffic(input int target);
		int         pick;
		int         n;
		logic [7:0] status;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_header();
			end else if (pick < 40) begin
				status = 8'($urandom_range(8'h80, 8'hEF));
				send_status(status);
				repeat ($urandom_range(1, 3))
					repeat (data_count(status))
						send_data(7'($urandom_range(0, 127)));
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 4))
					send_data(7'($urandom_range(0, 127)));
			end else if (pick < 75) begin
				send_status(bmsp_pkg::SYSEX_START);
				n = $urandom_range(0, 12);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(4) == 0)
						send_status(8'($urandom_range(8'hF8, 8'hFF)));
					send_data(7'($urandom_range(0, 127)));
				end
				// Mostly close cleanly; otherwise restart or interrupt.
				pick = $urandom_range(9);
				if (pick < 7)
					send_status(bmsp_pkg::SYSEX_END);
				else if (pick == 7)
					send_status(bmsp_pkg::SYSEX_START);
				else if (pick == 8)
					send_status(8'($urandom_range(8'h80, 8'hEF)));
				else
					send_status(8'($urandom_range(8'hF1, 8'hF6)));
			end else if (pick < 82) begin
				send_status(8'($urandom_range(8'hF8, 8'hFF)));
			end else if (pick < 87) begin
				send_status(8'($urandom_range(8'hF1, 8'hF6)));
			end else if (pick < 90) begin
				send_status(bmsp_pkg::SYSEX_END);
			end else begin
				// Raw noise, framing included.
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom_range(0, 255)), $urandom_range(7) == 0);
			end
		end
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		directed_traffic();
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 63; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			// Walk the SysEx buffer edge: fits exactly, end overflows, data overflows.
			if (p < 3)
				long_sysex(254 + p);
			random_traffic(ITEM_TARGET * (p + 1) / 4);
			while (items_accepted < items_queued)
				@(negedge clk);
			@(posedge clk);
		end
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d packet bytes over four idle/stall phases", items_accepted);
		$display("checked %0d channel, %0d sysex byte, %0d complete, %0d abandon results",
			kind_seen[bmsp_pkg::KIND_CHANNEL], kind_seen[bmsp_pkg::KIND_SYSEX_BYTE],
			kind_seen[bmsp_pkg::KIND_SYSEX_DONE], kind_seen[bmsp_pkg::KIND_SYSEX_ABANDON]);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
